@@ rtl/llsf_pkg.sv @@
// ----------------------------------------------------------------------------
// llsf_pkg
// Types and constants for the least-squares line fit core: request and
// result layouts, sample and accumulator widths, divider sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package llsf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 8;
  localparam int COUNT_W  = 16;
  localparam int OUT_W    = 32;
  localparam int TOTAL_W  = 16;

  localparam int SUM_W    = SAMPLE_W + COUNT_W;
  localparam int PSUM_W   = 2 * SAMPLE_W + COUNT_W;
  localparam int MPL_W    = SUM_W;
  localparam int DEN_W    = 2 * SUM_W;
  localparam int ACC_W    = 96;
  localparam int DIV_BITS = 88;
  localparam int DIVCNT_W = $clog2(DIV_BITS);
  localparam int QUO_W    = OUT_W + 2;

  localparam int SLOPE_SHIFT = 16;
  localparam int ICPT_SHIFT  = 16 - FRAC_W;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_value;
    logic signed [SAMPLE_W-1:0] y_value;
    logic                       last_point;
  } point_req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] slope;
    logic signed [OUT_W-1:0] intercept;
    logic                    degenerate;
    logic [TOTAL_W-1:0]      point_total;
  } fit_result_t;

endpackage

`default_nettype wire

@@ rtl/linear_least_squares_fit_core.sv @@
// ----------------------------------------------------------------------------
// linear_least_squares_fit_core
// Accumulates count, sum x, sum y, sum xy and sum xx over a stream of points
// and, on the point marked last, emits the rounded and saturated Q16.16
// slope and intercept of the least-squares line, then clears the sums.
//
//   channel   ports                   direction  transfer
//   request   start, busy, req        in         start high and busy low
//   result    done, result            out        done high for one cycle
//
// Sums, products and quotients use one shared 96-bit adder: shift-add multiplies
// (one multiplier bit per cycle, ending early on a zero multiplier) and a
// restoring divider (one quotient bit per cycle, 88 steps per quotient).
// For a plain point, the time busy stays high is set by the two 16-bit products.
// The last point adds six products of up to 32 steps and two divisions, or two
// products and zero outputs if degenerate. busy is high while an item is worked.
// Synchronous reset clears the sums and the sequencer; no clearing pass.
// The result cannot be stalled: it is shown for the one cycle of done.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_least_squares_fit_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire llsf_pkg::point_req_t req,
  output logic                      done,
  output llsf_pkg::fit_result_t     result
);

  localparam int W  = llsf_pkg::ACC_W;
  localparam int SW = llsf_pkg::SAMPLE_W;
  localparam int CW = llsf_pkg::COUNT_W;
  localparam int MW = llsf_pkg::MPL_W;
  localparam int DW = llsf_pkg::DEN_W;
  localparam int QW = llsf_pkg::QUO_W;
  localparam int OW = llsf_pkg::OUT_W;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_ADD_X     = 4'd1;
  localparam logic [3:0] ST_ADD_Y     = 4'd2;
  localparam logic [3:0] ST_MUL_LOAD  = 4'd3;
  localparam logic [3:0] ST_MUL       = 4'd4;
  localparam logic [3:0] ST_MUL_END   = 4'd5;
  localparam logic [3:0] ST_DIV_LOAD  = 4'd6;
  localparam logic [3:0] ST_DIV       = 4'd7;
  localparam logic [3:0] ST_ROUND     = 4'd8;
  localparam logic [3:0] ST_ROUND_ADD = 4'd9;
  localparam logic [3:0] ST_SAT       = 4'd10;

  localparam logic [2:0] TERM_XY     = 3'd0;
  localparam logic [2:0] TERM_XX     = 3'd1;
  localparam logic [2:0] TERM_N_SXX  = 3'd2;
  localparam logic [2:0] TERM_SX_SX  = 3'd3;
  localparam logic [2:0] TERM_N_SXY  = 3'd4;
  localparam logic [2:0] TERM_SX_SY  = 3'd5;
  localparam logic [2:0] TERM_SY_SXX = 3'd6;
  localparam logic [2:0] TERM_SX_SXY = 3'd7;

  localparam logic [CW-1:0] COUNT_MAX = '1;
  localparam logic [OW-1:0] POS_MAX   = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] NEG_MAX   = {1'b1, {(OW-1){1'b0}}};

  logic [3:0]                       state;
  logic [2:0]                       term;
  logic signed [SW-1:0]             x_reg;
  logic signed [SW-1:0]             y_reg;
  logic                             last_reg;
  logic [CW-1:0]                    count;
  logic signed [llsf_pkg::SUM_W-1:0]  sx;
  logic signed [llsf_pkg::SUM_W-1:0]  sy;
  logic signed [llsf_pkg::PSUM_W-1:0] sxy;
  logic signed [llsf_pkg::PSUM_W-1:0] sxx;
  logic [W-1:0]                     acc;
  logic [W-1:0]                     mcand;
  logic [MW-1:0]                    mplier;
  logic                             msub;
  logic [DW-1:0]                    den;
  logic [DW-1:0]                    rem;
  logic [QW-1:0]                    quo;
  logic                             big;
  logic                             nneg;
  logic [llsf_pkg::DIVCNT_W-1:0]    div_cnt;
  logic signed [OW-1:0]             slope;

  logic [W-1:0]          add_a;
  logic [W-1:0]          add_b;
  logic                  add_sub;
  logic [W-1:0]          add_sum;

  logic [W-1:0]          mc_sel;
  logic signed [MW-1:0]  mp_sel;
  logic [W-1:0]          init_acc;
  logic                  term_keep;
  logic                  term_sub;
  logic [MW-1:0]         mp_mag;
  logic [W-1:0]          num_mag;
  logic                  qbit;
  logic                  degen_now;
  logic                  fit_end;
  logic                  mag_big;
  logic [OW-1:0]         sat_val;

  // shared adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state)
      ST_ADD_X: begin
        add_a = W'(sx);
        add_b = W'(x_reg);
      end
      ST_ADD_Y: begin
        add_a = W'(sy);
        add_b = W'(y_reg);
      end
      ST_MUL: begin
        add_a   = acc;
        add_b   = mcand;
        add_sub = msub;
      end
      ST_DIV_LOAD: begin
        add_b   = acc;
        add_sub = 1'b1;
      end
      ST_DIV: begin
        add_a   = W'({rem, acc[llsf_pkg::DIV_BITS-1]});
        add_b   = W'(den);
        add_sub = 1'b1;
      end
      ST_ROUND: begin
        add_a   = W'({rem, 1'b0});
        add_b   = W'(den);
        add_sub = 1'b1;
      end
      ST_ROUND_ADD: begin
        add_a = W'(quo);
        add_b = W'(1);
      end
      default: begin
        add_a = '0;
      end
    endcase
    add_sum = add_a + (add_sub ? ~add_b : add_b) + W'(add_sub);
  end

  // operand selection per product term
  always_comb begin
    mc_sel    = '0;
    mp_sel    = '0;
    init_acc  = '0;
    term_keep = 1'b0;
    term_sub  = 1'b0;
    unique case (term)
      TERM_XY: begin
        mc_sel   = W'(x_reg);
        mp_sel   = MW'(y_reg);
        init_acc = W'(sxy);
      end
      TERM_XX: begin
        mc_sel   = W'(x_reg);
        mp_sel   = MW'(x_reg);
        init_acc = W'(sxx);
      end
      TERM_N_SXX: begin
        mc_sel = W'(sxx);
        mp_sel = MW'(count);
      end
      TERM_SX_SX: begin
        mc_sel    = W'(sx);
        mp_sel    = MW'(sx);
        term_keep = 1'b1;
        term_sub  = 1'b1;
      end
      TERM_N_SXY: begin
        mc_sel = W'(sxy);
        mp_sel = MW'(count);
      end
      TERM_SX_SY: begin
        mc_sel    = W'(sx);
        mp_sel    = MW'(sy);
        term_keep = 1'b1;
        term_sub  = 1'b1;
      end
      TERM_SY_SXX: begin
        mc_sel = W'(sxx);
        mp_sel = MW'(sy);
      end
      TERM_SX_SXY: begin
        mc_sel    = W'(sxy);
        mp_sel    = MW'(sx);
        term_keep = 1'b1;
        term_sub  = 1'b1;
      end
      default: begin
        mc_sel = '0;
      end
    endcase
    mp_mag = mp_sel[MW-1] ? (MW'(0) - mp_sel) : mp_sel;
  end

  always_comb begin
    num_mag   = acc[W-1] ? add_sum : acc;
    qbit      = ~add_sum[W-1];
    degen_now = (count < CW'(2)) || (acc == '0) || acc[W-1];
    fit_end   = ((state == ST_MUL_END) && (term == TERM_SX_SX) && degen_now) ||
                ((state == ST_SAT) && (term == TERM_SX_SXY));
    mag_big   = big || (|quo[QW-1:OW]);
    if (!nneg) begin
      sat_val = (mag_big || quo[OW-1]) ? POS_MAX : quo[OW-1:0];
    end else if (mag_big || (quo[OW-1] && (|quo[OW-2:0]))) begin
      sat_val = NEG_MAX;
    end else begin
      sat_val = OW'(0) - quo[OW-1:0];
    end
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      term  <= TERM_XY;
      done  <= 1'b0;
      count <= '0;
      sx    <= '0;
      sy    <= '0;
      sxy   <= '0;
      sxx   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            x_reg    <= req.x_value;
            y_reg    <= req.y_value;
            last_reg <= req.last_point;
            if (count != COUNT_MAX) begin
              state <= ST_ADD_X;
            end else if (req.last_point) begin
              term  <= TERM_N_SXX;
              state <= ST_MUL_LOAD;
            end
          end
        end
        ST_ADD_X: begin
          sx    <= add_sum[llsf_pkg::SUM_W-1:0];
          state <= ST_ADD_Y;
        end
        ST_ADD_Y: begin
          sy    <= add_sum[llsf_pkg::SUM_W-1:0];
          term  <= TERM_XY;
          state <= ST_MUL_LOAD;
        end
        ST_MUL_LOAD: begin
          mcand  <= mc_sel;
          mplier <= mp_mag;
          msub   <= term_sub ^ mp_sel[MW-1];
          if (!term_keep) begin
            acc <= init_acc;
          end
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (mplier == '0) begin
            state <= ST_MUL_END;
          end else begin
            if (mplier[0]) begin
              acc <= add_sum;
            end
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
          end
        end
        ST_MUL_END: begin
          case (term) inside
            TERM_XY: begin
              sxy   <= acc[llsf_pkg::PSUM_W-1:0];
              term  <= TERM_XX;
              state <= ST_MUL_LOAD;
            end
            TERM_XX: begin
              sxx   <= acc[llsf_pkg::PSUM_W-1:0];
              count <= count + CW'(1);
              if (last_reg) begin
                term  <= TERM_N_SXX;
                state <= ST_MUL_LOAD;
              end else begin
                state <= ST_IDLE;
              end
            end
            TERM_SX_SX: begin
              den <= acc[DW-1:0];
              if (degen_now) begin
                state <= ST_IDLE;
              end else begin
                term  <= TERM_N_SXY;
                state <= ST_MUL_LOAD;
              end
            end
            TERM_SX_SY, TERM_SX_SXY: begin
              state <= ST_DIV_LOAD;
            end
            default: begin
              term  <= term + 3'd1;
              state <= ST_MUL_LOAD;
            end
          endcase
        end
        ST_DIV_LOAD: begin
          nneg <= acc[W-1];
          if (term == TERM_SX_SY) begin
            acc <= num_mag << llsf_pkg::SLOPE_SHIFT;
          end else begin
            acc <= num_mag << llsf_pkg::ICPT_SHIFT;
          end
          rem     <= '0;
          quo     <= '0;
          big     <= 1'b0;
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          acc <= acc << 1;
          if (qbit) begin
            rem <= add_sum[DW-1:0];
          end else begin
            rem <= {rem[DW-2:0], acc[llsf_pkg::DIV_BITS-1]};
          end
          quo     <= {quo[QW-2:0], qbit};
          big     <= big | quo[QW-1];
          div_cnt <= div_cnt + llsf_pkg::DIVCNT_W'(1);
          if (div_cnt == llsf_pkg::DIVCNT_W'(llsf_pkg::DIV_BITS - 1)) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          state <= qbit ? ST_ROUND_ADD : ST_SAT;
        end
        ST_ROUND_ADD: begin
          quo   <= add_sum[QW-1:0];
          big   <= big | (|add_sum[W-1:QW]);
          state <= ST_SAT;
        end
        ST_SAT: begin
          if (term == TERM_SX_SY) begin
            slope <= sat_val;
            term  <= TERM_SY_SXX;
            state <= ST_MUL_LOAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (fit_end) begin
        done                <= 1'b1;
        result.degenerate   <= (state == ST_MUL_END);
        result.slope        <= (state == ST_MUL_END) ? '0 : slope;
        result.intercept    <= (state == ST_MUL_END) ? '0 : sat_val;
        result.point_total  <= llsf_pkg::TOTAL_W'(count);
        count <= '0;
        sx    <= '0;
        sy    <= '0;
        sxy   <= '0;
        sxx   <= '0;
      end
    end
  end

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_MUL_END) || ($past(state) == ST_SAT))
    else $error("result strobe without a finished fit");

  a_cleared: assert property (@(posedge clk) disable iff (rst)
    done |-> (count == '0) && (sx == '0) && (sy == '0) && (sxy == '0) && (sxx == '0))
    else $error("sums not cleared after fit");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.degenerate) |-> (result.slope == '0) && (result.intercept == '0))
    else $error("degenerate fit with nonzero outputs");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (den != '0))
    else $error("division by zero denominator");

endmodule

`default_nettype wire
